// ===== hdl/buddy_page_allocator_macros.svh =====
// Assertion macros for the buddy page allocator.
// Depends on a clk and rst signal in the module that uses them.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPA_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bpa_pkg.sv =====
// Shared constants, types and tables of the buddy page allocator.
// No dependencies.
package bpa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int NUM_ORDERS = 11;
  localparam int TOP_ORDER  = NUM_ORDERS - 1;
  localparam int PAGE_W     = 12;
  localparam int ORD_W      = 4;
  localparam int CNT_W      = 13;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int RREL_W     = PAGE_W - BIT_W;

  function automatic int rows_at(int k);
    int n;
    n = (NUM_PAGES >> k) + WORD_W - 1;
    return n / WORD_W;
  endfunction

  function automatic int total_rows();
    int s;
    s = 0;
    for (int k = 0; k < NUM_ORDERS; k++) s += rows_at(k);
    return s;
  endfunction

  localparam int ROWS  = total_rows();
  localparam int ROW_W = $clog2(ROWS);

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BIT_W-1:0]  bsel_t;
  typedef logic [ORD_W-1:0]  ord_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [RREL_W-1:0] rrow_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef row_t  row_tab_t  [NUM_ORDERS];
  typedef rrow_t rrow_tab_t [NUM_ORDERS];

  typedef struct packed {
    ord_t  ord;
    page_t idx;
  } map_ref_t;

  typedef struct packed {
    row_t  row;
    bsel_t bsel;
  } map_loc_t;

  function automatic row_tab_t make_row_base();
    row_tab_t t;
    int s;
    s = 0;
    for (int k = 0; k < NUM_ORDERS; k++) begin
      t[k] = row_t'(s);
      s += rows_at(k);
    end
    return t;
  endfunction

  function automatic rrow_tab_t make_row_last();
    rrow_tab_t t;
    for (int k = 0; k < NUM_ORDERS; k++) t[k] = rrow_t'(rows_at(k) - 1);
    return t;
  endfunction

  function automatic word_t make_top_mask();
    word_t m;
    m = '0;
    for (int i = 0; i < WORD_W; i++) m[i] = (i < (NUM_PAGES >> TOP_ORDER));
    return m;
  endfunction

  localparam row_tab_t  ROW_BASE = make_row_base();
  localparam rrow_tab_t ROW_LAST = make_row_last();
  localparam word_t     TOP_MASK = make_top_mask();
  localparam cnt_t      TOP_CNT  = cnt_t'(NUM_PAGES >> TOP_ORDER);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  function automatic bsel_t lowest_bit(word_t w);
    bsel_t b;
    b = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) b = bsel_t'(i);
    end
    return b;
  endfunction

endpackage

// ===== hdl/bpa_ram.sv =====
// Single-port RAM with registered read data, holding the free bitmap rows.
// No dependencies.
module bpa_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/bpa_addr.sv =====
// Shared address unit: maps an order and block index to a bitmap row and bit.
// Depends on bpa_pkg.
module bpa_addr (
  input  bpa_pkg::map_ref_t ref_in,
  output bpa_pkg::map_loc_t loc
);
  import bpa_pkg::*;

  always_comb begin
    loc.row  = ROW_BASE[ref_in.ord] + row_t'(ref_in.idx >> BIT_W);
    loc.bsel = ref_in.idx[BIT_W-1:0];
  end

endmodule

// ===== hdl/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: sequencer, free counts and bitmap.
// Depends on bpa_pkg, bpa_addr, bpa_ram and buddy_page_allocator_macros.svh.
//
// A request (op, order, page_index) is taken on a clock edge where start is
// high and busy is low. busy stays high until the request is finished; done is
// registered and pulses in the cycle after the last step for exactly one cycle
// with status, block_page and block_order. The receiver cannot hold results off.
// The bitmap keeps one bit per block of every order in 32-bit rows of a
// single-port RAM; each row touched is read in a read state and then tested
// or rewritten in the state that follows:
//   allocate: skip orders whose free count is zero, scan the rows of the first
//             order with a free block, then mark the split-off halves free;
//   free:     check for overlap in every order (11 to 68 rows, growing with
//             the order), merge with the buddy while it is free, then set the bit.
// Bad or failed requests finish early with zero page and order.
// After rst a clearing pass over all 258 bitmap rows sets the top-order
// blocks free and clears the rest; busy is high during it.
module buddy_page_allocator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 op,
  input  bpa_pkg::ord_t        order,
  input  bpa_pkg::page_t       page_index,
  output logic                 done,
  output logic [1:0]           status,
  output bpa_pkg::page_t       block_page,
  output bpa_pkg::ord_t        block_order
);
  import bpa_pkg::*;
`include "buddy_page_allocator_macros.svh"

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CHK      = 4'd2;
  localparam logic [3:0] S_AORD     = 4'd3;
  localparam logic [3:0] S_ARD      = 4'd4;
  localparam logic [3:0] S_AUSE     = 4'd5;
  localparam logic [3:0] S_SPLIT_RD = 4'd6;
  localparam logic [3:0] S_SPLIT_WR = 4'd7;
  localparam logic [3:0] S_OV_RD    = 4'd8;
  localparam logic [3:0] S_OV_USE   = 4'd9;
  localparam logic [3:0] S_MG_RD    = 4'd10;
  localparam logic [3:0] S_MG_USE   = 4'd11;
  localparam logic [3:0] S_FIN_RD   = 4'd12;
  localparam logic [3:0] S_FIN_WR   = 4'd13;

  logic [3:0]        state, state_next;
  logic              req_op, req_op_next;
  ord_t              req_ord, req_ord_next;
  page_t             req_page, req_page_next;
  ord_t              cur_ord, cur_ord_next;
  ord_t              top_ord, top_ord_next;
  logic [PAGE_W:0]   cur_page, cur_page_next;
  page_t             base_page, base_page_next;
  rrow_t             cur_row, cur_row_next;
  row_t              clr_row, clr_row_next;
  logic              done_next;
  logic [1:0]        status_next;
  page_t             block_page_next;
  ord_t              block_order_next;
  cnt_t              free_count [NUM_ORDERS];

  map_ref_t          aref;
  map_loc_t          loc;
  logic              we;
  row_t              ram_addr;
  word_t             wdata, rdata;
  logic              cnt_we, cnt_up;
  ord_t              cnt_idx;

  page_t             ord_mask, last, ov_lo, ov_hi, next_lo, buddy, bidx, cur_idx, base;
  rrow_t             lo_row, hi_row;
  bsel_t             lo_b, hi_b, low;
  word_t             ov_mask, bit_mask;
  logic [PAGE_W:0]   blocks_cur;

  bpa_addr u_addr (
    .ref_in (aref),
    .loc    (loc)
  );

  bpa_ram #(
    .DEPTH (ROWS),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (ram_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign busy     = (state != S_IDLE);
  assign ram_addr = (state == S_CLR) ? clr_row : loc.row;

  always_comb begin
    ord_mask   = ~(page_t'('1) << req_ord);
    last       = req_page | ord_mask;
    ov_lo      = req_page >> cur_ord;
    ov_hi      = (cur_ord < req_ord) ? (last >> cur_ord) : ov_lo;
    next_lo    = req_page >> ord_t'(cur_ord + 1'b1);
    lo_row     = rrow_t'(ov_lo >> BIT_W);
    hi_row     = rrow_t'(ov_hi >> BIT_W);
    lo_b       = (cur_row == lo_row) ? ov_lo[BIT_W-1:0] : '0;
    hi_b       = (cur_row == hi_row) ? ov_hi[BIT_W-1:0] : '1;
    ov_mask    = (word_t'('1) << lo_b) & (word_t'('1) >> (bsel_t'(WORD_W - 1) - hi_b));
    buddy      = cur_page[PAGE_W-1:0] ^ (page_t'(1) << cur_ord);
    bidx       = buddy >> cur_ord;
    cur_idx    = cur_page[PAGE_W-1:0] >> cur_ord;
    low        = lowest_bit(rdata);
    base       = page_t'({cur_row, low}) << cur_ord;
    bit_mask   = word_t'(1) << loc.bsel;
    blocks_cur = (PAGE_W + 1)'(NUM_PAGES) >> cur_ord;
  end

  always_comb begin
    state_next       = state;
    req_op_next      = req_op;
    req_ord_next     = req_ord;
    req_page_next    = req_page;
    cur_ord_next     = cur_ord;
    top_ord_next     = top_ord;
    cur_page_next    = cur_page;
    base_page_next   = base_page;
    cur_row_next     = cur_row;
    clr_row_next     = clr_row;
    done_next        = 1'b0;
    status_next      = status;
    block_page_next  = block_page;
    block_order_next = block_order;
    aref.ord         = cur_ord;
    aref.idx         = page_t'({cur_row, bsel_t'(0)});
    we               = 1'b0;
    wdata            = rdata;
    cnt_we           = 1'b0;
    cnt_up           = 1'b0;
    cnt_idx          = cur_ord;

    case (state)
      S_CLR: begin
        we    = 1'b1;
        wdata = (clr_row == ROW_BASE[TOP_ORDER]) ? TOP_MASK : '0;
        clr_row_next = row_t'(clr_row + 1'b1);
        if (clr_row == row_t'(ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_op_next   = op;
          req_ord_next  = order;
          req_page_next = page_index;
          state_next    = S_CHK;
        end
      end
      S_CHK: begin
        if (req_ord > ord_t'(TOP_ORDER) ||
            (req_op == OP_FREE &&
             ({1'b0, req_page} >= (PAGE_W + 1)'(NUM_PAGES) ||
              (req_page & ord_mask) != '0))) begin
          done_next        = 1'b1;
          status_next      = ST_BAD;
          block_page_next  = '0;
          block_order_next = '0;
          state_next       = S_IDLE;
        end else if (req_op == OP_ALLOC) begin
          cur_ord_next = req_ord;
          state_next   = S_AORD;
        end else begin
          cur_ord_next = '0;
          cur_row_next = rrow_t'(req_page >> BIT_W);
          state_next   = S_OV_RD;
        end
      end
      S_AORD: begin
        if (cur_ord == ord_t'(NUM_ORDERS)) begin
          done_next        = 1'b1;
          status_next      = ST_NOMEM;
          block_page_next  = '0;
          block_order_next = '0;
          state_next       = S_IDLE;
        end else if (free_count[cur_ord] != '0) begin
          cur_row_next = '0;
          state_next   = S_ARD;
        end else begin
          cur_ord_next = ord_t'(cur_ord + 1'b1);
        end
      end
      S_ARD: begin
        state_next = S_AUSE;
      end
      S_AUSE: begin
        if (rdata != '0) begin
          aref.idx       = page_t'({cur_row, low});
          we             = 1'b1;
          wdata          = rdata & ~(word_t'(1) << low);
          cnt_we         = 1'b1;
          base_page_next = base;
          cur_page_next  = {1'b0, base} + ((PAGE_W + 1)'(1) << req_ord);
          top_ord_next   = cur_ord;
          cur_ord_next   = req_ord;
          if (cur_ord == req_ord) begin
            done_next        = 1'b1;
            status_next      = ST_OK;
            block_page_next  = base;
            block_order_next = req_ord;
            state_next       = S_IDLE;
          end else begin
            state_next = S_SPLIT_RD;
          end
        end else if (cur_row == ROW_LAST[cur_ord]) begin
          cur_ord_next = ord_t'(cur_ord + 1'b1);
          state_next   = S_AORD;
        end else begin
          cur_row_next = rrow_t'(cur_row + 1'b1);
          state_next   = S_ARD;
        end
      end
      S_SPLIT_RD: begin
        aref.idx   = cur_idx;
        state_next = S_SPLIT_WR;
      end
      S_SPLIT_WR: begin
        aref.idx      = cur_idx;
        we            = 1'b1;
        wdata         = rdata | bit_mask;
        cnt_we        = 1'b1;
        cnt_up        = 1'b1;
        cur_page_next = cur_page + ((PAGE_W + 1)'(1) << cur_ord);
        cur_ord_next  = ord_t'(cur_ord + 1'b1);
        if (ord_t'(cur_ord + 1'b1) == top_ord) begin
          done_next        = 1'b1;
          status_next      = ST_OK;
          block_page_next  = base_page;
          block_order_next = req_ord;
          state_next       = S_IDLE;
        end else begin
          state_next = S_SPLIT_RD;
        end
      end
      S_OV_RD: begin
        state_next = S_OV_USE;
      end
      S_OV_USE: begin
        if ((rdata & ov_mask) != '0) begin
          done_next        = 1'b1;
          status_next      = ST_BAD;
          block_page_next  = '0;
          block_order_next = '0;
          state_next       = S_IDLE;
        end else if (cur_row != hi_row) begin
          cur_row_next = rrow_t'(cur_row + 1'b1);
          state_next   = S_OV_RD;
        end else if (cur_ord == ord_t'(TOP_ORDER)) begin
          cur_ord_next  = req_ord;
          cur_page_next = {1'b0, req_page};
          state_next    = (req_ord == ord_t'(TOP_ORDER)) ? S_FIN_RD : S_MG_RD;
        end else begin
          cur_ord_next = ord_t'(cur_ord + 1'b1);
          cur_row_next = rrow_t'(next_lo >> BIT_W);
          state_next   = S_OV_RD;
        end
      end
      S_MG_RD: begin
        aref.idx   = bidx;
        state_next = ({1'b0, bidx} >= blocks_cur) ? S_FIN_RD : S_MG_USE;
      end
      S_MG_USE: begin
        aref.idx = bidx;
        if ((rdata & bit_mask) != '0) begin
          we            = 1'b1;
          wdata         = rdata & ~bit_mask;
          cnt_we        = 1'b1;
          cur_page_next = {1'b0, cur_page[PAGE_W-1:0] & ~(page_t'(1) << cur_ord)};
          cur_ord_next  = ord_t'(cur_ord + 1'b1);
          state_next    = (ord_t'(cur_ord + 1'b1) == ord_t'(TOP_ORDER)) ? S_FIN_RD : S_MG_RD;
        end else begin
          state_next = S_FIN_RD;
        end
      end
      S_FIN_RD: begin
        aref.idx   = cur_idx;
        state_next = S_FIN_WR;
      end
      S_FIN_WR: begin
        aref.idx         = cur_idx;
        we               = 1'b1;
        wdata            = rdata | bit_mask;
        cnt_we           = 1'b1;
        cnt_up           = 1'b1;
        done_next        = 1'b1;
        status_next      = ST_OK;
        block_page_next  = cur_page[PAGE_W-1:0];
        block_order_next = cur_ord;
        state_next       = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_row <= '0;
      done    <= 1'b0;
      for (int k = 0; k < NUM_ORDERS; k++) begin
        free_count[k] <= (k == TOP_ORDER) ? TOP_CNT : '0;
      end
    end else begin
      state   <= state_next;
      clr_row <= clr_row_next;
      done    <= done_next;
      if (cnt_we) begin
        free_count[cnt_idx] <= cnt_up ? cnt_t'(free_count[cnt_idx] + 1'b1)
                                      : cnt_t'(free_count[cnt_idx] - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    req_op      <= req_op_next;
    req_ord     <= req_ord_next;
    req_page    <= req_page_next;
    cur_ord     <= cur_ord_next;
    top_ord     <= top_ord_next;
    cur_page    <= cur_page_next;
    base_page   <= base_page_next;
    cur_row     <= cur_row_next;
    status      <= status_next;
    block_page  <= block_page_next;
    block_order <= block_order_next;
  end

  `BPA_CHECK(a_fail_zero, done && status != ST_OK,
             block_page == '0 && block_order == '0,
             "failed request returned a nonzero block")
  `BPA_CHECK(a_ok_aligned, done && status == ST_OK,
             ((block_page >> block_order) << block_order) == block_page,
             "returned block is not aligned to its order")
  `BPA_CHECK_NEXT(a_take_busy, start && !busy, busy && !done,
                  "accepted request did not hold the block busy")

endmodule
